// File: hw/rtl/qshp_pkg.sv
`default_nettype none
package qshp_pkg;
   localparam int MaxItems  = 64;
   localparam int DataWidth = 32;
   localparam int IdxW      = $clog2(MaxItems);
   localparam int CntW      = $clog2(MaxItems + 1);
   localparam int StackDepth = MaxItems;
   localparam int SpW       = $clog2(StackDepth + 1);
   localparam int QDepth    = 2;

   typedef struct packed {
      logic [DataWidth-1:0] value;
      logic                 is_last;
   } item_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_POP, ST_PIV, ST_SCAN_I, ST_SCAN_J, ST_SWAP_A, ST_SWAP_B,
      ST_PUSH, ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT
   } state_type;

   function automatic logic lt_signed(input logic [DataWidth-1:0] a,
                                      input logic [DataWidth-1:0] b);
      lt_signed = $signed(a) < $signed(b);
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/qshp_ram.sv
`default_nettype none
module qshp_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/qshp_front.sv
`default_nettype none
module qshp_front import qshp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [31:0]          req_value,
   input  wire logic                 req_is_last,
   output logic                      q_valid,
   output item_type                  q_item,
   input  wire logic                 q_pop
);
   item_type                   slot_ff [QDepth];
   logic [$clog2(QDepth)-1:0]  wp_ff, rp_ff;
   logic [$clog2(QDepth):0]    cnt_ff;
   logic                       push;

   assign req_stall = (cnt_ff == ($clog2(QDepth)+1)'(QDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= '{value: req_value[DataWidth-1:0], is_last: req_is_last};
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (q_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(q_pop);
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/qshp_back.sv
`default_nettype none
module qshp_back import qshp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_sorted_value,
   output logic             rsp_is_last_out,
   output logic             rsp_overflow
);
   state_type state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [SpW-1:0]   sp_ff, sp_in;
   logic [IdxW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [IdxW+1:0]  si_ff, si_in, sj_ff, sj_in;
   logic [DataWidth-1:0] piv_ff, piv_in, a_ff, a_in;
   logic [IdxW-1:0]  k_ff, k_in;
   logic             ov_ff, ov_in;
   logic [DataWidth-1:0] ov_val_ff, ov_val_in;
   logic             ov_last_ff, ov_last_in, ov_ovf_ff, ov_ovf_in;
   logic [1:0]       pcnt_ff, pcnt_in;

   logic                 m_we;
   logic [IdxW-1:0]      m_wa, m_ra;
   logic [DataWidth-1:0] m_wd, m_rd;
   logic                 s_we;
   logic [IdxW-1:0]      s_wa, s_ra;
   logic [2*IdxW-1:0]    s_wd, s_rd;

   qshp_ram #(.Width(DataWidth), .Depth(MaxItems)) u_store (
      .clock, .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd), .rd_addr(m_ra), .rd_data(m_rd));
   qshp_ram #(.Width(2*IdxW), .Depth(StackDepth)) u_stack (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));

   logic [IdxW+1:0] lo_x, hi_x, i_x, j_x;
   logic [IdxW-1:0] jj, ii;
   logic            push_l, push_r, larger_left;
   logic            ov_free;
   always_comb begin
      lo_x = (IdxW+2)'(lo_ff);
      hi_x = (IdxW+2)'(hi_ff);
      i_x  = si_ff;
      j_x  = ($signed(sj_ff) > $signed(lo_x)) ? sj_ff : lo_x;
      ii   = i_x[IdxW-1:0];
      jj   = j_x[IdxW-1:0];
      push_l = $signed(lo_x) < $signed(j_x);
      push_r = $signed(i_x) < $signed(hi_x);
      larger_left = (j_x - lo_x) > (hi_x - i_x);
      ov_free = !ov_ff || !rsp_stall;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:   if (q_valid && q_item.is_last)
                       state_in = (count_in < CntW'(2)) ? ST_EMIT_RD : ST_POP;
         ST_POP:    if (sp_ff == '0) state_in = ST_EMIT_RD;
                    else if (pcnt_ff == 2'd2) state_in = ST_PIV;
         ST_PIV:    if (pcnt_ff == 2'd1) state_in = ST_SCAN_I;
         ST_SCAN_I: if (pcnt_ff == 2'd1 && !lt_signed(m_rd, piv_ff)) state_in = ST_SCAN_J;
         ST_SCAN_J: if (pcnt_ff == 2'd1 && !lt_signed(piv_ff, m_rd))
                       state_in = ($signed(si_ff) <= $signed(sj_ff)) ? ST_SWAP_A : ST_PUSH;
         ST_SWAP_A: state_in = ST_SWAP_B;
         ST_SWAP_B: state_in = ($signed(si_ff + 1'b1) <= $signed(sj_ff - 1'b1))
                               ? ST_SCAN_I : ST_PUSH;
         ST_PUSH:   if (pcnt_ff == 2'd1) state_in = ST_POP;
         ST_EMIT_RD:   state_in = (count_ff == '0) ? ST_LOAD : ST_EMIT_WAIT;
         ST_EMIT_WAIT: state_in = ST_EMIT;
         ST_EMIT:   if (ov_free)
                       state_in = (CntW'(k_ff) + 1'b1 == count_ff) ? ST_LOAD : ST_EMIT_WAIT;
         default:   state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in = count_ff; ovf_in = ovf_ff; sp_in = sp_ff;
      lo_in = lo_ff; hi_in = hi_ff; si_in = si_ff; sj_in = sj_ff;
      piv_in = piv_ff; a_in = a_ff; k_in = k_ff;
      ov_in = ov_ff && rsp_stall; ov_val_in = ov_val_ff;
      ov_last_in = ov_last_ff; ov_ovf_in = ov_ovf_ff; pcnt_in = 2'd0;
      q_pop = 1'b0; m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = '0;
      s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (count_ff < CntW'(MaxItems)) begin
                  m_we = 1'b1; m_wa = count_ff[IdxW-1:0];
                  m_wd = q_item.value; count_in = count_ff + 1'b1;
               end else ovf_in = 1'b1;
               if (q_item.is_last) begin
                  k_in = '0;
                  s_we = 1'b1; s_wa = '0;
                  s_wd = {IdxW'(0), IdxW'(count_in - 1'b1)};
                  sp_in = SpW'(1);
               end
            end
         end
         ST_POP: begin
            s_ra = IdxW'(sp_ff - 1'b1);
            pcnt_in = pcnt_ff + 1'b1;
            if (pcnt_ff == 2'd2) begin
               sp_in = sp_ff - 1'b1;
               lo_in = s_rd[2*IdxW-1:IdxW]; hi_in = s_rd[IdxW-1:0];
               si_in = (IdxW+2)'(s_rd[2*IdxW-1:IdxW]);
               sj_in = (IdxW+2)'(s_rd[IdxW-1:0]);
               pcnt_in = 2'd0;
            end
         end
         ST_PIV: begin
            m_ra = IdxW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
            pcnt_in = pcnt_ff + 1'b1;
            if (pcnt_ff == 2'd1) begin piv_in = m_rd; pcnt_in = 2'd0; end
         end
         ST_SCAN_I: begin
            m_ra = si_ff[IdxW-1:0];
            pcnt_in = 2'd1;
            if (pcnt_ff == 2'd1) begin
               if (lt_signed(m_rd, piv_ff)) begin
                  si_in = si_ff + 1'b1; pcnt_in = 2'd0;
               end else begin a_in = m_rd; pcnt_in = 2'd0; end
            end
         end
         ST_SCAN_J: begin
            m_ra = sj_ff[IdxW-1:0];
            pcnt_in = 2'd1;
            if (pcnt_ff == 2'd1) begin
               pcnt_in = 2'd0;
               if (lt_signed(piv_ff, m_rd)) sj_in = sj_ff - 1'b1;
               else piv_in = piv_ff;
            end
         end
         ST_SWAP_A: begin
            m_ra = sj_ff[IdxW-1:0];
            m_we = 1'b1; m_wa = sj_ff[IdxW-1:0]; m_wd = a_ff;
            a_in = m_rd;
         end
         ST_SWAP_B: begin
            m_we = 1'b1; m_wa = si_ff[IdxW-1:0]; m_wd = a_ff;
            si_in = si_ff + 1'b1; sj_in = sj_ff - 1'b1;
         end
         ST_PUSH: begin
            pcnt_in = pcnt_ff + 1'b1;
            if ((pcnt_ff == 2'd0) == larger_left) begin
               if (push_l && sp_ff < SpW'(StackDepth)) begin
                  s_we = 1'b1; s_wa = IdxW'(sp_ff); s_wd = {lo_ff, jj};
                  sp_in = sp_ff + 1'b1;
               end
            end else if (push_r && sp_ff < SpW'(StackDepth)) begin
               s_we = 1'b1; s_wa = IdxW'(sp_ff); s_wd = {ii, hi_ff};
               sp_in = sp_ff + 1'b1;
            end
            if (pcnt_ff == 2'd1) pcnt_in = 2'd0;
         end
         ST_EMIT_RD: begin
            k_in = '0;
            if (count_ff == '0) ovf_in = 1'b0;
         end
         ST_EMIT_WAIT: m_ra = k_ff;
         ST_EMIT: begin
            m_ra = k_ff;
            if (ov_free) begin
               ov_in = 1'b1; ov_val_in = m_rd;
               ov_last_in = (CntW'(k_ff) + 1'b1 == count_ff);
               ov_ovf_in = ovf_ff;
               k_in = k_ff + 1'b1;
               if (ov_last_in) begin count_in = '0; ovf_in = 1'b0; sp_in = '0; end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in; hi_ff <= hi_in; si_ff <= si_in; sj_ff <= sj_in;
      piv_ff <= piv_in; a_ff <= a_in; k_ff <= k_in;
      ov_val_ff <= ov_val_in; ov_last_ff <= ov_last_in; ov_ovf_ff <= ov_ovf_in;
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; ovf_ff <= 1'b0; sp_ff <= '0;
         ov_ff <= 1'b0; pcnt_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ovf_ff <= ovf_in; sp_ff <= sp_in;
         ov_ff <= ov_in; pcnt_ff <= pcnt_in;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_sorted_value = 32'($signed(ov_val_ff));
   assign rsp_is_last_out  = ov_last_ff;
   assign rsp_overflow     = ov_ovf_ff;
endmodule
`default_nettype wire

// File: hw/rtl/quicksort_hoare_partition_unit.sv
// Loading: one item per cycle through a two-entry queue into the item store
// while the queue is not full. Sort: iterative Hoare partition, each step
// waiting on the single read port of the item store.
// Output: sorted values leave the registered output stage, held while stalled.
// Reset (synchronous, active high) empties the set, stack and queue.
`default_nettype none
module quicksort_hoare_partition_unit import qshp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_value,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_sorted_value,
   output logic             rsp_is_last_out,
   output logic             rsp_overflow
);
   logic     q_valid, q_pop;
   item_type q_item;

   qshp_front u_front (.clock, .reset, .req_valid, .req_stall, .req_value,
      .req_is_last, .q_valid, .q_item, .q_pop);
   qshp_back u_back (.clock, .reset, .q_valid, .q_item, .q_pop, .rsp_valid,
      .rsp_stall, .rsp_sorted_value, .rsp_is_last_out, .rsp_overflow);
endmodule
`default_nettype wire

// File: hw/rtl/qshp_checker.sv
`default_nettype none
module qshp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_sorted_value,
   input wire logic        rsp_is_last_out
);
   logic last_ff, have_ff;
   logic [31:0] prev_ff;
   always_ff @(posedge clock) begin
      if (reset) begin last_ff <= 1'b1; have_ff <= 1'b0; end
      else if (rsp_valid && !rsp_stall) begin
         last_ff <= rsp_is_last_out; have_ff <= 1'b1; prev_ff <= rsp_sorted_value;
      end
   end
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && have_ff && !last_ff |-> $signed(rsp_sorted_value) >= $signed(prev_ff))
      else $error("sorted output descends");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sorted_value))
      else $error("stalled result changed");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule
bind quicksort_hoare_partition_unit qshp_checker u_chk (.clock, .reset, .rsp_valid,
   .rsp_stall, .rsp_sorted_value, .rsp_is_last_out);
`default_nettype wire

// File: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import qshp_pkg::*;

   localparam int CycleLimit = 2000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_sorted_value;
   logic        rsp_is_last_out;
   logic        rsp_overflow;

   typedef struct packed {
      logic [31:0] value;
      logic        last;
      logic        ovf;
   } sorted_type;

   item_type   pending_items[$];
   sorted_type sorted_expect[$];
   logic [31:0] set_values[$];
   logic        set_overflow;
   int          error_count;
   int          cycle_count;
   int          send_gap;
   int          take_gap;
   bit          calm;
   bit          loaded;

   quicksort_hoare_partition_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_value(req_value), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sorted_value(rsp_sorted_value), .rsp_is_last_out(rsp_is_last_out),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // record each accepted transfer; predict the sorted set on the last one
   task automatic sort_set(input logic [31:0] v, input logic last);
      logic [31:0] vals[$];
      sorted_type  s;
      if (set_values.size() < MaxItems) set_values.push_back(v);
      else set_overflow = 1'b1;
      if (!last) return;
      vals = set_values;
      for (int a = 1; a < vals.size(); a++)
         for (int b = a; b > 0 && $signed(vals[b]) < $signed(vals[b-1]); b--) begin
            logic [31:0] t;
            t = vals[b]; vals[b] = vals[b-1]; vals[b-1] = t;
         end
      foreach (vals[k]) begin
         s.value = vals[k];
         s.last = (k == vals.size() - 1);
         s.ovf = set_overflow;
         sorted_expect.push_back(s);
      end
      set_values.delete();
      set_overflow = 1'b0;
   endtask

   function automatic logic [31:0] rand_value(input int kind);
      case (kind)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(15);
         3: return 32'hffff_fff0 | $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_set(input int n);
      item_type it;
      int kind;
      kind = $urandom_range(7);
      for (int k = 0; k < n; k++) begin
         it.value = (kind < 2) ? rand_value($urandom_range(3)) : rand_value(4);
         it.is_last = (k == n - 1);
         pending_items.push_back(it);
      end
   endtask

   initial begin
      item_type it;
      int total;
      set_overflow = 1'b0;
      it.value = 32'h8000_0000; it.is_last = 1'b1; pending_items.push_back(it);
      it.value = 32'h7fff_ffff; it.is_last = 1'b0; pending_items.push_back(it);
      it.value = 32'h8000_0000; it.is_last = 1'b0; pending_items.push_back(it);
      it.value = 32'h0000_0000; it.is_last = 1'b0; pending_items.push_back(it);
      it.value = 32'hffff_ffff; it.is_last = 1'b0; pending_items.push_back(it);
      it.value = 32'h0000_0001; it.is_last = 1'b0; pending_items.push_back(it);
      it.value = 32'h0000_0001; it.is_last = 1'b1; pending_items.push_back(it);
      for (int k = 0; k < 8; k++) begin
         it.value = 32'd8 - k; it.is_last = (k == 7); pending_items.push_back(it);
      end
      // store full: last-marked item dropped, then a full set exactly
      queue_set(66);
      queue_set(64);
      total = pending_items.size();
      while (total < 350) begin
         int n;
         n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
         queue_set(n);
         total += n;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
         req_is_last <= 1'b0;
         send_gap <= 0;
         loaded <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            sort_set(req_value, req_is_last);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
               it_out();
               if (!calm && $urandom_range(5) == 0) send_gap <= $urandom_range(1, 17);
            end else begin
               req_valid <= 1'b0;
               loaded <= 1'b1;
            end
         end
      end
   end

   task automatic it_out();
      item_type it;
      it = pending_items.pop_front();
      req_valid <= 1'b1;
      req_value <= it.value;
      req_is_last <= it.is_last;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         take_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_expect.size() == 0) begin
               report("unexpected result", rsp_sorted_value, 32'h0);
            end else begin
               sorted_type s;
               s = sorted_expect.pop_front();
               if (rsp_sorted_value !== s.value) report("value", rsp_sorted_value, s.value);
               if (rsp_is_last_out !== s.last) report("last", rsp_is_last_out, s.last);
               if (rsp_overflow !== s.ovf) report("overflow", rsp_overflow, s.ovf);
            end
         end
         if (take_gap > 0) begin
            rsp_stall <= 1'b1;
            take_gap <= take_gap - 1;
         end else if (!calm && $urandom_range(6) == 0) begin
            rsp_stall <= 1'b1;
            take_gap <= $urandom_range(0, 16);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm <= (pending_items.size() < 60);
      if (cycle_count > CycleLimit) begin
         $display("timeout");
         $display("quicksort_hoare_partition_unit regression: fail");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      req_is_last = 1'b0;
      rsp_stall = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (loaded);
      wait (sorted_expect.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("quicksort_hoare_partition_unit regression: pass");
      end else begin
         $display("quicksort_hoare_partition_unit regression: fail");
      end
      $finish;
   end
endmodule
